// File: src/lru_key_value_cache_defines.svh
// Assertion macros shared by the LRU key-value cache RTL.
`ifndef LRU_KEY_VALUE_CACHE_DEFINES_SVH
`define LRU_KEY_VALUE_CACHE_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define LKV_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define LKV_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: src/lkv_pkg.sv
// Types and constants of the LRU key-value cache.
`default_nettype none
package lkv_pkg;

  localparam int unsigned MAX_ENTRIES_DEF = 16;
  localparam int unsigned KEY_W           = 32;
  localparam int unsigned VAL_W           = 32;
  localparam int unsigned CAP_W           = 5;
  localparam logic [CAP_W-1:0] CAP_RESET  = 5'd16;

  typedef enum logic {
    OP_GET = 1'b0,
    OP_PUT = 1'b1
  } op_e;

  typedef struct packed {
    op_e                     op;
    logic signed [KEY_W-1:0] key;
    logic signed [VAL_W-1:0] value;
  } req_t;

  typedef struct packed {
    logic                    found;
    logic signed [VAL_W-1:0] read_value;
  } rsp_t;

  typedef struct packed {
    logic signed [KEY_W-1:0] key;
    logic signed [VAL_W-1:0] value;
  } entry_t;

endpackage
`default_nettype wire

// File: src/lkv_cell.sv
// One cell of the recency-ordered entry chain: holds an entry and compares its key.
`default_nettype none
module lkv_cell (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           take_i,
  input  wire lkv_pkg::entry_t                entry_i,
  input  wire logic                           valid_i,
  input  wire logic signed [lkv_pkg::KEY_W-1:0] cmp_key_i,
  output lkv_pkg::entry_t                     entry_o,
  output logic                                valid_o,
  output logic                                match_o
);
  import lkv_pkg::*;

  entry_t entry_q;
  logic   valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (take_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_i) begin
      entry_q <= entry_i;
    end
  end

  assign entry_o = entry_q;
  assign valid_o = valid_q;
  assign match_o = valid_q && (entry_q.key == cmp_key_i);

endmodule
`default_nettype wire

// File: src/lru_key_value_cache.sv
// LRU key-value cache: a chain of cells kept in recency order, cell 0 most recent.
// A request word passes a compare state across all cells, then an update state that shifts
// the chain; its result word is registered as the update completes, which waits while the
// output register is stalled. A new request word may be accepted as an update completes.
// Reset clears all valid marks and the occupancy and sets capacity to 16; no clearing pass.
`default_nettype none
module lru_key_value_cache #(
  parameter int unsigned MAX_ENTRIES = lkv_pkg::MAX_ENTRIES_DEF
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       in_valid_i,
  output logic                            in_stall_o,
  input  wire lkv_pkg::req_t              in_data_i,
  output logic                            out_valid_o,
  input  wire logic                       out_stall_i,
  output lkv_pkg::rsp_t                   out_data_o,
  input  wire logic                       cfg_valid_i,
  output logic                            cfg_ready_o,
  input  wire logic [lkv_pkg::CAP_W-1:0]  cfg_data_i
);
  import lkv_pkg::*;

`include "lru_key_value_cache_defines.svh"

  localparam int unsigned OCC_W = $clog2(MAX_ENTRIES + 1);
  localparam int unsigned LIM_W = (OCC_W > CAP_W) ? OCC_W : CAP_W;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_CMP  = 3'b010,
    ST_UPD  = 3'b100
  } state_e;

  state_e                  state_q, state_d;
  req_t                    req_q;
  logic [MAX_ENTRIES-1:0]  hit_vec_q;
  logic signed [VAL_W-1:0] hit_val_q, hit_val_d;
  logic [OCC_W-1:0]        occ_q;
  logic [CAP_W-1:0]        cap_q;
  logic                    out_valid_q;
  rsp_t                    out_data_q, out_data_d;

  entry_t                  cell_ent [MAX_ENTRIES];
  entry_t                  cell_in  [MAX_ENTRIES];
  logic [MAX_ENTRIES-1:0]  valid_vec, valid_in, match_vec, take_vec;

  logic                    in_go, upd_go, found, is_put, evict;
  logic [LIM_W-1:0]        cap_ext, occ_ext, max_ext, limit;

  assign found  = |hit_vec_q;
  assign is_put = (req_q.op == OP_PUT);

  // Capacity zero counts as one, anything above the chain length as the chain length.
  assign cap_ext = LIM_W'(cap_q);
  assign occ_ext = LIM_W'(occ_q);
  assign max_ext = LIM_W'(MAX_ENTRIES);
  assign limit   = (cap_ext == '0) ? LIM_W'(1) : ((cap_ext > max_ext) ? max_ext : cap_ext);
  assign evict   = (occ_ext >= limit);

  assign upd_go      = (state_q == ST_UPD) && (!out_valid_q || !out_stall_i);
  assign in_stall_o  = !((state_q == ST_IDLE) || upd_go);
  assign in_go       = in_valid_i && !in_stall_o;
  assign cfg_ready_o = (state_q == ST_IDLE);

  // The cell that moves to the head is always the request key; its value is the new one
  // for a put and the stored one for a get hit.
  for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
    if (i == 0) begin : g_head
      assign cell_in[i].key   = req_q.key;
      assign cell_in[i].value = is_put ? req_q.value : hit_val_q;
      assign valid_in[i]      = 1'b1;
      assign take_vec[i]      = upd_go && (found || is_put);
    end else begin : g_body
      localparam logic [OCC_W-1:0] Pos = OCC_W'(i);
      assign cell_in[i]  = cell_ent[i-1];
      assign valid_in[i] = valid_vec[i-1];
      // A hit shifts every cell up to the hit position; a new key shifts up to the
      // least recent entry (dropping it) or one past it when there is room.
      assign take_vec[i] = upd_go && (found ? (|hit_vec_q[MAX_ENTRIES-1:i])
                                            : (is_put && ((Pos < occ_q) ||
                                                          (!evict && (Pos == occ_q)))));
    end

    lkv_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .take_i    (take_vec[i]),
      .entry_i   (cell_in[i]),
      .valid_i   (valid_in[i]),
      .cmp_key_i (req_q.key),
      .entry_o   (cell_ent[i]),
      .valid_o   (valid_vec[i]),
      .match_o   (match_vec[i])
    );
  end

  always_comb begin
    hit_val_d = '0;
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      hit_val_d = hit_val_d | (match_vec[i] ? cell_ent[i].value : '0);
    end
  end

  always_comb begin
    out_data_d.found      = found;
    out_data_d.read_value = (found && !is_put) ? hit_val_q : '0;
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_go) state_d = ST_CMP;
      end
      ST_CMP: begin
        state_d = ST_UPD;
      end
      ST_UPD: begin
        if (upd_go) state_d = in_go ? ST_CMP : ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      occ_q       <= '0;
      cap_q       <= CAP_RESET;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i && cfg_ready_o) begin
        cap_q <= cfg_data_i;
      end
      if (upd_go && is_put && !found && !evict) begin
        occ_q <= occ_q + OCC_W'(1);
      end
      if (upd_go) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_go) begin
      req_q <= in_data_i;
    end
    if (state_q == ST_CMP) begin
      hit_vec_q <= match_vec;
      hit_val_q <= hit_val_d;
    end
    if (upd_go) begin
      out_data_q <= out_data_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  `LKV_ASSERT_NOW(a_hit_unique, state_q == ST_UPD, $onehot0(hit_vec_q), "more than one cell hit")
  `LKV_ASSERT_NOW(a_occ_count, 1'b1, OCC_W'($countones(valid_vec)) == occ_q, "occupancy is off")
  `LKV_ASSERT_NOW(a_occ_bound, 1'b1, occ_q <= OCC_W'(MAX_ENTRIES), "occupancy beyond chain length")
  `LKV_ASSERT_NEXT(a_upd_result, upd_go, out_valid_o, "update finished without a result word")
  `LKV_ASSERT_NEXT(a_accept_cmp, in_go, state_q == ST_CMP, "accepted word did not enter compare")

endmodule
`default_nettype wire
